### sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/mrm_pkg.sv
`timescale 1ns / 1ps
package mrm_pkg;

   localparam int VOICES       = 16;
   localparam int SAMPLE_BYTES = 65536;

   localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int VCNT_W  = $clog2(VOICES + 1);
   localparam int SADDR_W = $clog2(SAMPLE_BYTES);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_MIXER_ENABLED = '0;

   // sample arithmetic
   localparam int SILENCE    = 128;
   localparam int VOL_FULL   = 127;
   localparam int PAN_SPAN   = 256;
   localparam int GAIN_SHIFT = 8;

   // volume divide by reciprocal, q0 is exact or one short
   localparam int DIV_K = 29;
   localparam logic [22:0] DIV_R = 23'((64'd1 << DIV_K) / VOL_FULL);

   // step = rate * 2^STEP_FRAC / OUT_RATE by reciprocal
   localparam int OUT_RATE  = 48000;
   localparam int STEP_FRAC = 16;
   localparam int STEP_K    = 48;
   localparam logic [32:0] STEP_R = 33'((65'd1 << STEP_K) / OUT_RATE);

   typedef enum logic [2:0] {
      KIND_WRITE = 3'd0,
      KIND_START = 3'd1,
      KIND_SET   = 3'd2,
      KIND_STOP  = 3'd3,
      KIND_QUERY = 3'd4,
      KIND_MIX   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STEP,
      ST_MIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  voice;
      logic [15:0] address;
      logic [7:0]  sample_byte;
      logic [16:0] length;
      logic [15:0] rate;
      logic [6:0]  volume;
      logic [7:0]  pan;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               playing;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [15:0] base;
      logic [16:0] length;
      logic [31:0] position;
      logic [16:0] step;
      logic [6:0]  volume;
      logic [7:0]  pan;
   } voice_entry_type;

endpackage

### sv/mrm_ram.sv
`timescale 1ns / 1ps
module mrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/multichannel_resampling_mixer.sv
`timescale 1ns / 1ps
// channel   direction  payload    handshake
// req_      in         req_type   req_valid / req_ready
// rsp_      out        rsp_type   rsp_valid / rsp_ready
// csr_      in/out     32-bit     apb write at psel & penable & pwrite, pready tied high
//
// one beat in flight: write, set, stop and query pass through exec and done, start adds a step state unless refused
// a mix beat is refused when disabled; otherwise the voice walk issues one voice memory read
// per cycle, then a 6-stage sample pipeline drains
// synchronous reset clears voice_active, the mixer enable and the handshake state
// a finished result waits in the output register while the next beat is taken
module multichannel_resampling_mixer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mrm_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mrm_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mrm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mrm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mrm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import mrm_pkg::*;

   // control state
   state_type         state_ff, state_in;
   logic              enabled_ff;
   logic [VOICES-1:0] active_ff, active_in;
   logic [VCNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload state
   req_type            item_ff;
   rsp_type            result_ff, result_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [16:0]        step_q0_ff, step_q0_in;
   logic signed [15:0] acc_l_ff, acc_l_in;
   logic signed [15:0] acc_r_ff, acc_r_in;

   // voice memory
   logic                        vram_we;
   logic [VIDX_W-1:0]           vram_waddr, vram_raddr;
   voice_entry_type             vram_wdata, vram_rdata;
   logic [$bits(voice_entry_type)-1:0] vram_rbits;

   // sample memory
   logic               sram_we;
   logic [SADDR_W-1:0] sram_waddr, sram_raddr;
   logic [7:0]         sram_rdata;

   logic              item_vok;
   logic [VIDX_W-1:0] item_vidx, req_vidx, issue_vidx;

   mrm_ram #(
      .WIDTH ($bits(voice_entry_type)),
      .DEPTH (VOICES)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (vram_waddr),
      .wr_data (vram_wdata),
      .rd_addr (vram_raddr),
      .rd_data (vram_rbits)
   );
   assign vram_rdata = vram_rbits;

   mrm_ram #(
      .WIDTH (8),
      .DEPTH (SAMPLE_BYTES)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (sram_we),
      .wr_addr (sram_waddr),
      .wr_data (item_ff.sample_byte),
      .rd_addr (sram_raddr),
      .rd_data (sram_rdata)
   );

   assign item_vok   = (32'(item_ff.voice) < 32'(VOICES));
   assign item_vidx  = VIDX_W'(item_ff.voice);
   assign req_vidx   = VIDX_W'(req_data.voice);
   assign issue_vidx = issue_cnt_ff[VIDX_W-1:0];
   assign sram_waddr = SADDR_W'(item_ff.address);

   // ---------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------
   logic csr_sel_enable;
   assign csr_sel_enable = (csr_paddr[CSR_ADDR_W-1:2] == REG_MIXER_ENABLED);
   assign csr_pready     = 1'b1;
   assign csr_prdata     = csr_sel_enable ? CSR_DATA_W'(enabled_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_enable) begin
         enabled_ff <= csr_pwdata[0];
      end
   end

   // ---------------------------------------------------------------
   // step = rate * 65536 / 48000: reciprocal estimate, then one correction
   // ---------------------------------------------------------------
   logic [48:0] step_prod;
   logic [32:0] step_num, step_back, step_rem;
   logic [16:0] step_val;

   assign step_prod  = 49'(item_ff.rate) * 49'(STEP_R);
   assign step_q0_in = step_prod[STEP_K-STEP_FRAC+16:STEP_K-STEP_FRAC];
   assign step_num   = {1'b0, item_ff.rate, {STEP_FRAC{1'b0}}};
   assign step_back  = 33'(step_q0_ff) * 33'(OUT_RATE);
   assign step_rem   = step_num - step_back;
   assign step_val   = step_q0_ff + 17'(step_rem >= 33'(OUT_RATE));

   // ---------------------------------------------------------------
   // voice walk pipeline
   // p1: voice entry back, decide live, write position, issue sample read
   // p2: sample back, centre and scale by volume
   // p3: reciprocal multiply for the divide by 127
   // p4: correct quotient, apply sign
   // p5: pan gains
   // p6: floor shift and saturating accumulate
   // ---------------------------------------------------------------
   logic              p1_vld_ff, p1_vld_in;
   logic [VIDX_W-1:0] p1_idx_ff;
   logic              p1_act, p1_live;
   logic [15:0]       p1_pos;
   logic [16:0]       p1_addr_sum;

   assign p1_act      = active_ff[p1_idx_ff];
   assign p1_pos      = vram_rdata.position[31:16];
   assign p1_live     = p1_act && ({1'b0, p1_pos} < vram_rdata.length);
   assign p1_addr_sum = {1'b0, vram_rdata.base} + {1'b0, p1_pos};
   assign sram_raddr  = SADDR_W'(p1_addr_sum);

   logic       p2_vld_ff;
   logic [6:0] p2_vol_ff;
   logic [7:0] p2_pan_ff;
   logic       p2_neg;
   logic [7:0] p2_mag;

   assign p2_neg = (sram_rdata < 8'(SILENCE));
   assign p2_mag = p2_neg ? 8'(9'(SILENCE) - {1'b0, sram_rdata})
                          : 8'({1'b0, sram_rdata} - 9'(SILENCE));

   logic        p3_vld_ff, p3_neg_ff;
   logic [14:0] p3_x_ff;
   logic [7:0]  p3_pan_ff;
   logic [22:0] p3_m;
   logic [45:0] p3_prod;

   assign p3_m    = {p3_x_ff, {GAIN_SHIFT{1'b0}}};
   assign p3_prod = 46'(p3_m) * 46'(DIV_R);

   logic        p4_vld_ff, p4_neg_ff;
   logic [22:0] p4_m_ff;
   logic [15:0] p4_q0_ff;
   logic [7:0]  p4_pan_ff;
   logic [22:0] p4_back, p4_rem;
   logic [15:0] p4_q;
   logic signed [16:0] p4_s;

   assign p4_back = {p4_q0_ff, 7'b0} - 23'(p4_q0_ff);
   assign p4_rem  = p4_m_ff - p4_back;
   assign p4_q    = p4_q0_ff + 16'(p4_rem >= 23'(VOL_FULL));
   assign p4_s    = p4_neg_ff ? -signed'({1'b0, p4_q}) : signed'({1'b0, p4_q});

   logic               p5_vld_ff;
   logic signed [16:0] p5_s_ff;
   logic [7:0]         p5_pan_ff;
   logic signed [9:0]  p5_gl, p5_gr;
   logic signed [26:0] p5_pl, p5_pr;

   assign p5_gl = signed'(10'(PAN_SPAN) - {2'b0, p5_pan_ff});
   assign p5_gr = signed'({2'b0, p5_pan_ff} + 10'd1);
   assign p5_pl = p5_s_ff * p5_gl;
   assign p5_pr = p5_s_ff * p5_gr;

   logic               p6_vld_ff;
   logic signed [26:0] p6_pl_ff, p6_pr_ff;
   logic signed [26:0] p6_shl, p6_shr;
   logic signed [18:0] p6_suml, p6_sumr;

   assign p6_shl  = p6_pl_ff >>> GAIN_SHIFT;
   assign p6_shr  = p6_pr_ff >>> GAIN_SHIFT;
   assign p6_suml = signed'(p6_shl[18:0]) + signed'({{3{acc_l_ff[15]}}, acc_l_ff});
   assign p6_sumr = signed'(p6_shr[18:0]) + signed'({{3{acc_r_ff[15]}}, acc_r_ff});

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      if (v > 19'sd32767) begin
         return 16'sh7fff;
      end else if (v < -19'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   logic pipe_busy;
   assign pipe_busy = p1_vld_ff || p2_vld_ff || p3_vld_ff || p4_vld_ff
                      || p5_vld_ff || p6_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         p6_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= p1_vld_in;
         p2_vld_ff <= p1_vld_ff && p1_live;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
         p6_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff <= issue_vidx;
      p2_vol_ff <= vram_rdata.volume;
      p2_pan_ff <= vram_rdata.pan;
      p3_x_ff   <= 15'(p2_mag) * 15'(p2_vol_ff);
      p3_neg_ff <= p2_neg;
      p3_pan_ff <= p2_pan_ff;
      p4_m_ff   <= p3_m;
      p4_q0_ff  <= p3_prod[DIV_K+15:DIV_K];
      p4_neg_ff <= p3_neg_ff;
      p4_pan_ff <= p3_pan_ff;
      p5_s_ff   <= p4_s;
      p5_pan_ff <= p4_pan_ff;
      p6_pl_ff  <= p5_pl;
      p6_pr_ff  <= p5_pr;
   end

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         issue_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         issue_cnt_ff <= issue_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
      step_q0_ff  <= step_q0_in;
      acc_l_ff    <= acc_l_in;
      acc_r_ff    <= acc_r_in;
   end

   always_comb begin
      state_in     = state_ff;
      result_in    = result_ff;
      active_in    = active_ff;
      issue_cnt_in = issue_cnt_ff;
      acc_l_in     = acc_l_ff;
      acc_r_in     = acc_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      p1_vld_in    = 1'b0;
      vram_we      = 1'b0;
      vram_waddr   = item_vidx;
      vram_wdata   = vram_rdata;
      vram_raddr   = req_vidx;
      sram_we      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            result_in = '0;
            state_in  = ST_DONE;
            case (item_ff.kind)
               KIND_WRITE: begin
                  sram_we = 1'b1;
               end
               KIND_START: begin
                  if (!enabled_ff || !item_vok) begin
                     result_in.status = 1'b1;
                  end else begin
                     state_in = ST_STEP;
                  end
               end
               KIND_SET: begin
                  // entry was read while the beat was taken
                  if (item_vok) begin
                     vram_we           = 1'b1;
                     vram_wdata.volume = item_ff.volume;
                     vram_wdata.pan    = item_ff.pan;
                  end
               end
               KIND_STOP: begin
                  if (item_vok) begin
                     active_in[item_vidx] = 1'b0;
                  end
               end
               KIND_QUERY: begin
                  result_in.playing = item_vok && active_ff[item_vidx];
               end
               KIND_MIX: begin
                  if (!enabled_ff) begin
                     result_in.status = 1'b1;
                  end else begin
                     state_in     = ST_MIX;
                     issue_cnt_in = '0;
                     acc_l_in     = '0;
                     acc_r_in     = '0;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_STEP: begin
            vram_we             = 1'b1;
            vram_wdata.base     = item_ff.address;
            vram_wdata.length   = item_ff.length;
            vram_wdata.position = '0;
            vram_wdata.step     = step_val;
            vram_wdata.volume   = item_ff.volume;
            vram_wdata.pan      = item_ff.pan;
            active_in[item_vidx] = 1'b1;
            state_in            = ST_DONE;
         end

         ST_MIX: begin
            vram_raddr = issue_vidx;
            if (issue_cnt_ff < VCNT_W'(VOICES)) begin
               p1_vld_in    = 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end else if (!pipe_busy) begin
               result_in.left  = acc_l_ff;
               result_in.right = acc_r_ff;
               state_in        = ST_DONE;
            end

            // position write-back goes to the voice issued last cycle
            if (p1_vld_ff) begin
               if (p1_act && !p1_live) begin
                  active_in[p1_idx_ff] = 1'b0;
               end else if (p1_live) begin
                  vram_we             = 1'b1;
                  vram_waddr          = p1_idx_ff;
                  vram_wdata.position = vram_rdata.position + 32'(vram_rdata.step);
               end
            end

            if (p6_vld_ff) begin
               acc_l_in = sat16(p6_suml);
               acc_r_in = sat16(p6_sumr);
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/mrm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input mrm_pkg::rsp_type rsp_data
);
   import mrm_pkg::*;

   // one beat at a time through the sequencer
   `ASSERT_NEXT(a_one_beat_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // a query answer that reports playing never carries audio or a refusal
   `ASSERT_ALWAYS(a_query_is_quiet, clock, reset, rsp_valid && rsp_data.playing |-> rsp_data.left == 16'sd0 && rsp_data.right == 16'sd0 && !rsp_data.status)

   // refused start and disabled mix are silent
   `ASSERT_ALWAYS(a_refused_is_silent, clock, reset, rsp_valid && rsp_data.status |-> rsp_data.left == 16'sd0 && rsp_data.right == 16'sd0)

   // reset drops any pending result
   `ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)

endmodule

bind multichannel_resampling_mixer mrm_checker u_mrm_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import mrm_pkg::*;

   // run shape
   localparam int RANDOM_BEATS = 1850;
   localparam int DRAIN_CYCLES = 2 * (VOICES + 9);
   localparam int PRINT_CAP    = 50;

   // pcm limits for the per-voice saturation
   localparam int PCM_MAX = 32767;
   localparam int PCM_MIN = -32768;

   // kinds the block must treat as no-ops
   localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR = CSR_ADDR_W'(4 * int'(REG_MIXER_ENABLED));

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   multichannel_resampling_mixer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------
   // mirror of the mixer: sample memory, voice table, enable bit
   // ---------------------------------------------------------------
   logic [7:0]  sound_mem     [0:SAMPLE_BYTES-1];
   bit          sound_written [0:SAMPLE_BYTES-1];
   bit          vc_active [0:VOICES-1];
   logic [15:0] vc_base   [0:VOICES-1];
   logic [16:0] vc_len    [0:VOICES-1];
   logic [31:0] vc_pos    [0:VOICES-1];
   logic [16:0] vc_step   [0:VOICES-1];
   logic [6:0]  vc_vol    [0:VOICES-1];
   logic [7:0]  vc_pan    [0:VOICES-1];
   bit          mix_on;

   // results in flight, oldest first
   rsp_type pending_results[$];

   // idle percentages, changed per phase by the stimulus
   int send_idle_pct;
   int recv_idle_pct;

   int errors;
   int beats_sent;
   int results_checked;
   int frames_mixed;
   int frames_clipped;
   int starts_taken;
   int fills_sent;
   int enable_writes;

   // directed stimulus: one row per beat, optional hand-written result
   typedef struct {
      bit      enable;
      req_type beat;
      bit      known;
      rsp_type result;
   } dir_row_type;

   dir_row_type dir_rows[$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < PRINT_CAP)
         $display("mismatch after %0d results: %s got %0d expected %0d",
                  results_checked, what, got, want);
      errors++;
   endtask

   function automatic int clip16(input int v);
      if (v > PCM_MAX) return PCM_MAX;
      if (v < PCM_MIN) return PCM_MIN;
      return v;
   endfunction

   // advance the mirror by one beat and return the result it must give
   function automatic rsp_type next_mix_result(input req_type b);
      rsp_type     r;
      int          acc_l, acc_r, s, sum_l, sum_r, i;
      logic [15:0] pos, addr;
      logic [31:0] scaled_rate;
      bit          clipped;
      r = '0;
      acc_l = 0;
      acc_r = 0;
      clipped = 1'b0;
      case (b.kind)
         KIND_WRITE: begin
            sound_mem[b.address] = b.sample_byte;
            sound_written[b.address] = 1'b1;
         end
         KIND_START: begin
            if (!mix_on || int'(b.voice) >= VOICES) begin
               r.status = 1'b1;
            end else begin
               vc_active[b.voice] = 1'b1;
               vc_base[b.voice]   = b.address;
               vc_len[b.voice]    = b.length;
               vc_pos[b.voice]    = '0;
               vc_vol[b.voice]    = b.volume;
               vc_pan[b.voice]    = b.pan;
               // step in 1.16 per output frame, unsigned divide
               scaled_rate = {b.rate, 16'h0000};
               vc_step[b.voice] = 17'(scaled_rate / 32'(OUT_RATE));
               starts_taken++;
            end
         end
         KIND_SET: begin
            if (int'(b.voice) < VOICES) begin
               vc_vol[b.voice] = b.volume;
               vc_pan[b.voice] = b.pan;
            end
         end
         KIND_STOP: begin
            if (int'(b.voice) < VOICES) vc_active[b.voice] = 1'b0;
         end
         KIND_QUERY: begin
            if (int'(b.voice) < VOICES) r.playing = vc_active[b.voice];
         end
         KIND_MIX: begin
            if (!mix_on) begin
               r.status = 1'b1;
            end else begin
               for (i = 0; i < VOICES; i++) begin
                  if (vc_active[i]) begin
                     pos = vc_pos[i][31:16];
                     if ({1'b0, pos} >= vc_len[i]) begin
                        vc_active[i] = 1'b0;
                     end else begin
                        addr = vc_base[i] + pos;
                        s = (int'(sound_mem[addr]) - SILENCE) * PAN_SPAN;
                        s = (s * int'(vc_vol[i])) / VOL_FULL;
                        // arithmetic shift rounds toward minus infinity
                        sum_l = acc_l + ((s * (PAN_SPAN - int'(vc_pan[i]))) >>> GAIN_SHIFT);
                        sum_r = acc_r + ((s * (int'(vc_pan[i]) + 1)) >>> GAIN_SHIFT);
                        if (sum_l != clip16(sum_l) || sum_r != clip16(sum_r)) clipped = 1'b1;
                        acc_l = clip16(sum_l);
                        acc_r = clip16(sum_r);
                        vc_pos[i] = vc_pos[i] + 32'(vc_step[i]);
                     end
                  end
               end
               frames_mixed++;
               if (clipped) frames_clipped++;
               r.left  = 16'(acc_l);
               r.right = 16'(acc_r);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_type rand_beat();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   task automatic add_row(input bit en, input int kind, input int voice, input int addr,
                          input int sbyte, input int len, input int rate, input int vol,
                          input int pan, input bit known, input int l, input int r,
                          input int p, input int s);
      dir_row_type row;
      row.enable             = en;
      row.beat.kind          = 3'(kind);
      row.beat.voice         = 4'(voice);
      row.beat.address       = 16'(addr);
      row.beat.sample_byte   = 8'(sbyte);
      row.beat.length        = 17'(len);
      row.beat.rate          = 16'(rate);
      row.beat.volume        = 7'(vol);
      row.beat.pan           = 8'(pan);
      row.known              = known;
      row.result.left        = 16'(l);
      row.result.right       = 16'(r);
      row.result.playing     = 1'(p);
      row.result.status      = 1'(s);
      dir_rows.push_back(row);
   endtask

   // drive one beat at a falling edge, after a random gap, and wait until taken
   task automatic push_beat(input req_type b, input bit known, input rsp_type given);
      rsp_type want;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_data  <= b;
      req_valid <= 1'b1;
      want = next_mix_result(b);
      pending_results.push_back(known ? given : want);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // a mix must never read an unwritten byte: fill every unwritten address the
   // active voices are about to read with random content first
   task automatic send_item(input req_type b, input bit known, input rsp_type given);
      int          i;
      logic [15:0] a;
      req_type     fill;
      if (b.kind == KIND_MIX && mix_on) begin
         for (i = 0; i < VOICES; i++) begin
            if (vc_active[i] && {1'b0, vc_pos[i][31:16]} < vc_len[i]) begin
               a = vc_base[i] + vc_pos[i][31:16];
               if (!sound_written[a]) begin
                  fill = rand_beat();
                  fill.kind = KIND_WRITE;
                  fill.address = a;
                  push_beat(fill, 1'b0, '0);
                  fills_sent++;
               end
            end
         end
      end
      push_beat(b, known, given);
   endtask

   // sender holds off until every result is back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // one apb transfer: setup phase, then access phase until pready
   task automatic csr_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ENABLE_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // enable is only touched with the block idle; upper data bits are noise
   task automatic set_enable(input bit en);
      logic [31:0] wd, rd;
      wait_idle();
      wd = ($urandom & ~32'd1) | 32'(en);
      csr_access(1'b1, wd, rd);
      mix_on = en;
      enable_writes++;
      csr_access(1'b0, '0, rd);
      if (rd !== 32'(en)) report_mismatch("mixer_enabled readback", int'(rd), int'(en));
   endtask

   // receiver: ready decided fresh at every falling edge
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing pending", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.left !== want.left)
               report_mismatch("left", int'(rsp_data.left), int'(want.left));
            if (rsp_data.right !== want.right)
               report_mismatch("right", int'(rsp_data.right), int'(want.right));
            if (rsp_data.playing !== want.playing)
               report_mismatch("playing", int'(rsp_data.playing), int'(want.playing));
            if (rsp_data.status !== want.status)
               report_mismatch("status", int'(rsp_data.status), int'(want.status));
         end
         results_checked++;
      end
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #16_000_000;
      $display("timeout with %0d results pending", pending_results.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int      j, k, n, bursts, pick, random_start;
      logic [15:0] base;
      logic [3:0]  v;
      req_type b;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      mix_on = 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 85;
      for (j = 0; j < VOICES; j++) begin
         vc_active[j] = 1'b0;
         vc_base[j]   = '0;
         vc_len[j]    = '0;
         vc_pos[j]    = '0;
         vc_step[j]   = '0;
         vc_vol[j]    = '0;
         vc_pan[j]    = '0;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // en kind voice addr byte len rate vol pan | known left right playing status
      // out of reset: enable is off, nothing playing
      add_row(0, KIND_QUERY, 0, 0, 0, 0, 0, 0, 0,                1, 0, 0, 0, 0);
      // disabled: silent frame and refused start
      add_row(0, KIND_MIX, 0, 0, 0, 0, 0, 0, 0,                  1, 0, 0, 0, 1);
      add_row(0, KIND_START, 3, 'h1234, 0, 10, 48000, 127, 128,  1, 0, 0, 0, 1);
      // unused kinds with every field at its extreme
      add_row(0, KIND_UNUSED_LO, 15, 'hFFFF, 255, 'h1FFFF, 'hFFFF, 127, 255, 1, 0, 0, 0, 0);
      add_row(0, KIND_UNUSED_HI, 0, 0, 0, 0, 0, 0, 0,            1, 0, 0, 0, 0);
      // writes still work while disabled: full-scale bytes at both ends
      add_row(0, KIND_WRITE, 0, 'hFFFF, 255, 0, 0, 0, 0,         1, 0, 0, 0, 0);
      add_row(0, KIND_WRITE, 0, 0, 0, 0, 0, 0, 0,                1, 0, 0, 0, 0);
      // voice 15 at the top of memory, step of one byte, wraps to address 0
      add_row(1, KIND_START, 15, 'hFFFF, 0, 2, 48000, 127, 0,    1, 0, 0, 0, 0);
      add_row(1, KIND_MIX, 0, 0, 0, 0, 0, 0, 0,                  1, 32512, 127, 0, 0);
      add_row(1, KIND_MIX, 0, 0, 0, 0, 0, 0, 0,                  1, -32768, -128, 0, 0);
      // position reaches the length: voice drops out
      add_row(1, KIND_MIX, 0, 0, 0, 0, 0, 0, 0,                  1, 0, 0, 0, 0);
      add_row(1, KIND_QUERY, 15, 0, 0, 0, 0, 0, 0,               1, 0, 0, 0, 0);
      // two full-scale voices hard left saturate the left channel
      add_row(1, KIND_START, 0, 'hFFFF, 0, 1, 0, 127, 0,         1, 0, 0, 0, 0);
      add_row(1, KIND_START, 1, 'hFFFF, 0, 'h1FFFF, 0, 127, 0,   1, 0, 0, 0, 0);
      add_row(1, KIND_MIX, 0, 0, 0, 0, 0, 0, 0,                  1, 32767, 254, 0, 0);
      // move voice 1 hard right
      add_row(1, KIND_SET, 1, 0, 0, 0, 0, 127, 255,              1, 0, 0, 0, 0);
      add_row(1, KIND_MIX, 0, 0, 0, 0, 0, 0, 0,                  0, 0, 0, 0, 0);
      add_row(1, KIND_STOP, 0, 0, 0, 0, 0, 0, 0,                 1, 0, 0, 0, 0);
      add_row(1, KIND_QUERY, 0, 0, 0, 0, 0, 0, 0,                1, 0, 0, 0, 0);
      add_row(1, KIND_QUERY, 1, 0, 0, 0, 0, 0, 0,                1, 0, 0, 1, 0);
      // zero length, top rate, zero volume
      add_row(1, KIND_START, 2, 0, 0, 0, 'hFFFF, 0, 128,         0, 0, 0, 0, 0);
      add_row(1, KIND_MIX, 0, 0, 0, 0, 0, 0, 0,                  0, 0, 0, 0, 0);
      // disabled with a voice still active: frame is silent, stop still acts
      add_row(0, KIND_MIX, 0, 0, 0, 0, 0, 0, 0,                  1, 0, 0, 0, 1);
      add_row(0, KIND_STOP, 1, 0, 0, 0, 0, 0, 0,                 1, 0, 0, 0, 0);
      add_row(0, KIND_QUERY, 1, 0, 0, 0, 0, 0, 0,                1, 0, 0, 0, 0);

      foreach (dir_rows[j]) begin
         if (dir_rows[j].enable != mix_on) set_enable(dir_rows[j].enable);
         send_item(dir_rows[j].beat, dir_rows[j].known, dir_rows[j].result);
      end

      set_enable(1'b1);
      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         // idle profile by thirds: sender light, then receiver light, then none
         if (beats_sent - random_start < RANDOM_BEATS / 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 85;
         end else if (beats_sent - random_start < 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 85;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // short disabled stretches now and then
         if (mix_on ? ($urandom_range(99) < 2) : ($urandom_range(99) < 30))
            set_enable(!mix_on);
         if ($urandom_range(199) == 0) wait_idle();

         pick = $urandom_range(99);
         if (pick < 55) begin
            // load a short sound, start a voice on it, then play it out
            v = 4'($urandom_range(VOICES - 1));
            base = 16'($urandom);
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++) begin
               b = rand_beat();
               b.kind = KIND_WRITE;
               b.address = base + 16'(k);
               send_item(b, 1'b0, '0);
            end
            b = rand_beat();
            b.kind = KIND_START;
            b.voice = v;
            b.address = base;
            k = $urandom_range(19);
            if (k == 0) b.length = 17'($urandom_range(65536, 131071));
            else if (k < 5) b.length = 17'(n + $urandom_range(0, 8));
            else b.length = 17'(n);
            if ($urandom_range(3) != 0) b.rate = 16'($urandom_range(8000, 65535));
            send_item(b, 1'b0, '0);
            bursts = $urandom_range(1, 12);
            for (k = 0; k < bursts; k++) begin
               if ($urandom_range(5) == 0) begin
                  b = rand_beat();
                  b.kind = KIND_SET;
                  b.voice = v;
                  send_item(b, 1'b0, '0);
               end
               b = rand_beat();
               b.kind = KIND_MIX;
               send_item(b, 1'b0, '0);
            end
         end else if (pick < 65) begin
            repeat ($urandom_range(1, 4)) begin
               b = rand_beat();
               b.kind = KIND_MIX;
               send_item(b, 1'b0, '0);
            end
         end else begin
            // noise: any kind, any content; most stray starts kept short
            b = rand_beat();
            b.kind = 3'($urandom_range(7));
            if (b.kind == KIND_START && $urandom_range(3) != 0)
               b.length = 17'($urandom_range(0, 40));
            send_item(b, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never returned", pending_results.size(), 0);

      $display("sent %0d beats (%0d fill writes), %0d results checked, %0d mismatches",
               beats_sent, fills_sent, results_checked, errors);
      $display("%0d starts taken, %0d frames mixed, %0d with clipping, %0d enable writes",
               starts_taken, frames_mixed, frames_clipped, enable_writes);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/mrm_pkg.sv
sv/mrm_ram.sv
sv/multichannel_resampling_mixer.sv
sv/mrm_checker.sv
tb/testbench.sv
